[hw/rtl/mnp_pkg.sv]
// ----------------------------------------------------------------------------
// mnp_pkg - shared definitions for the MIDI note pairing block
// Table geometry, MIDI status codes, register indexes and the table entry.
// ----------------------------------------------------------------------------
package mnp_pkg;

   localparam int NUM_CHANNELS     = 16;
   localparam int KEYS_PER_CHANNEL = 128;
   localparam int TABLE_DEPTH      = NUM_CHANNELS * KEYS_PER_CHANNEL;
   localparam int IDX_W            = $clog2(TABLE_DEPTH);

   localparam int SAMPLE_W = 48;
   localparam int RATIO_W  = 32;
   localparam int TICK_W   = 48;
   localparam int MIDI_W   = 7;
   localparam int CHAN_W   = 5;

   // MIDI status bytes
   localparam logic [7:0] STATUS_CHAN_MASK = 8'h0F;
   localparam logic [7:0] STATUS_TYPE_MASK = 8'hF0;
   localparam logic [7:0] STATUS_NOTE_ON   = 8'h90;
   localparam logic [7:0] STATUS_NOTE_OFF  = 8'h80;
   localparam logic [7:0] STATUS_CTRL      = 8'hB0;
   localparam logic [7:0] STATUS_SYSTEM    = 8'hF0;

   // input item modes and result kinds
   localparam logic MODE_EVENT = 1'b0;
   localparam logic MODE_FLUSH = 1'b1;
   localparam logic KIND_NOTE  = 1'b0;
   localparam logic KIND_CTRL  = 1'b1;

   // control and status register indexes
   localparam int          CSR_IDX_W            = 1;
   localparam int          CSR_DATA_W           = 48;
   localparam logic [CSR_IDX_W-1:0] CSR_TAKE_LENGTH      = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_SAMPLE = 1'd1;

   typedef struct packed {
      logic                valid;
      logic [SAMPLE_W-1:0] start;
      logic [MIDI_W-1:0]   velocity;
   } pend_entry_type;

endpackage

[hw/rtl/midi_note_pairing_top.sv]
// ----------------------------------------------------------------------------
// midi_note_pairing_top - note on/off pairing for one recorded MIDI track
//
// Input transfers (req_) carry one take-relative channel-voice event, or with
// req_mode set a flush of the hanging note named by the status low nibble and
// req_data_one. Result transfers (rsp_) carry a completed note, or a
// controller change with zero length. The csr_ channel writes the take length
// (index 0) and the Q0.32 ticks-per-sample ratio (index 1); it is always ready.
// The user must see it is written only while the block is idle (not enforced).
//
// The pending table is one 2048-entry synchronous RAM holding valid, start
// sample and velocity. After reset a clearing pass writes every entry, during
// which req_ready stays low.
//
// One item at a time: the table read is followed by the decode step, in which
// dropped events and Note On writes finish. Each sample-to-tick conversion
// takes a low and a high step on the shared 32x32 multiplier; a controller
// needs one conversion, a completed note two, before the output step.
// A result sits in the output register; the next item is accepted while it
// waits, and a second result holds the block until rsp_ready frees it.
// ----------------------------------------------------------------------------
module midi_note_pairing_top (
   input  logic                            clock,
   input  logic                            reset,
   // configuration write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mnp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mnp_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // input item channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_mode,
   input  logic [mnp_pkg::SAMPLE_W-1:0]    req_sample_pos,
   input  logic [7:0]                      req_status,
   input  logic [mnp_pkg::MIDI_W-1:0]      req_data_one,
   input  logic [mnp_pkg::MIDI_W-1:0]      req_data_two,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_kind,
   output logic [mnp_pkg::CHAN_W-1:0]      rsp_channel,
   output logic [mnp_pkg::MIDI_W-1:0]      rsp_number,
   output logic [mnp_pkg::MIDI_W-1:0]      rsp_value,
   output logic [mnp_pkg::TICK_W-1:0]      rsp_start_tick,
   output logic [mnp_pkg::TICK_W-1:0]      rsp_length_ticks
);
   import mnp_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_OUT
   } state_type;

   state_type            state_ff;
   logic [IDX_W-1:0]     clr_cnt_ff;

   // configuration
   logic [SAMPLE_W-1:0]  take_len_ff;
   logic [RATIO_W-1:0]   ratio_ff;

   // held item
   logic                 mode_ff;
   logic [SAMPLE_W-1:0]  pos_ff;
   logic [7:0]           status_ff;
   logic [MIDI_W-1:0]    d1_ff;
   logic [MIDI_W-1:0]    d2_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic                 has_row_ff;

   // conversion datapath
   logic                 pair_ff;
   logic                 second_ff;
   logic [SAMPLE_W-1:0]  opnd_ff;
   logic [31:0]          lo_ff;
   logic [TICK_W-1:0]    start_tick_ff;
   logic [TICK_W-1:0]    end_tick_ff;

   // result register
   logic                 rsp_valid_ff;
   logic                 rsp_kind_ff;
   logic [CHAN_W-1:0]    rsp_channel_ff;
   logic [MIDI_W-1:0]    rsp_number_ff;
   logic [MIDI_W-1:0]    rsp_value_ff;
   logic [TICK_W-1:0]    rsp_start_ff;
   logic [TICK_W-1:0]    rsp_length_ff;

   // pending table
   pend_entry_type       table_mem [TABLE_DEPTH];
   pend_entry_type       rd_ff;
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_waddr;
   pend_entry_type       mem_wdata;

   logic                 req_fire;
   logic [3:0]           req_ch0;
   logic [IDX_W-1:0]     req_idx;
   logic                 req_has_row;

   logic [SAMPLE_W-1:0]  eff_len;
   logic [7:0]           type_code;
   logic                 bad_status;
   logic                 late;
   logic                 hit;
   logic                 is_note_on;
   logic                 is_note_stop;
   logic                 is_ctrl;
   logic                 event_ok;

   logic [31:0]          mul_op;
   logic [63:0]          prod;
   logic [63:0]          acc;
   logic [TICK_W-1:0]    tick;
   logic                 out_free;
   logic [TICK_W-1:0]    note_len;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   // table index of the incoming item: row per channel, column per key
   assign req_ch0     = req_status[3:0];
   assign req_has_row = ({1'b0, req_ch0} < 5'(NUM_CHANNELS));
   assign req_idx     = IDX_W'(req_ch0) * IDX_W'(KEYS_PER_CHANNEL) + IDX_W'(req_data_one);

   assign eff_len    = (take_len_ff == '0) ? SAMPLE_W'(1) : take_len_ff;
   assign type_code  = status_ff & STATUS_TYPE_MASK;
   assign bad_status = (status_ff < STATUS_NOTE_OFF) || (status_ff >= STATUS_SYSTEM);
   assign late       = (pos_ff >= eff_len);
   assign hit        = has_row_ff && rd_ff.valid;
   assign is_note_on = (type_code == STATUS_NOTE_ON) && (d2_ff != '0);
   assign is_note_stop = (type_code == STATUS_NOTE_OFF) || (type_code == STATUS_NOTE_ON);
   assign is_ctrl    = (type_code == STATUS_CTRL);
   assign event_ok   = (mode_ff == MODE_EVENT) && !bad_status && !late;

   // ticks = floor(x * ratio / 2^32), as low 16 bits then high 32 bits of x
   assign mul_op = (state_ff == ST_MUL_LO) ? {16'b0, opnd_ff[15:0]} : opnd_ff[47:16];
   assign prod   = 64'(mul_op) * 64'(ratio_ff);
   assign acc    = prod + {32'b0, lo_ff};
   assign tick   = acc[63:16];

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign note_len = (end_tick_ff > start_tick_ff) ? (end_tick_ff - start_tick_ff)
                                                   : TICK_W'(1);

   // table writes: clearing pass, Note On store, and clearing a paired entry
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = idx_ff;
      mem_wdata = '0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_ff;
         end
         ST_LOOK: begin
            if (mode_ff == MODE_FLUSH) begin
               mem_we = hit;
            end else if (!bad_status && !late) begin
               if (is_note_on) begin
                  mem_we    = has_row_ff;
                  mem_wdata = '{valid: 1'b1, start: pos_ff, velocity: d2_ff};
               end else if (is_note_stop) begin
                  mem_we = hit;
               end
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      if (req_fire) begin
         rd_ff <= table_mem[req_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         take_len_ff  <= SAMPLE_W'(1);
         ratio_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TAKE_LENGTH:      take_len_ff <= csr_wdata[SAMPLE_W-1:0];
               CSR_TICKS_PER_SAMPLE: ratio_ff    <= csr_wdata[RATIO_W-1:0];
               default:              ;
            endcase
         end

         // the output step loads the register itself when it is taken
         if (rsp_valid_ff && rsp_ready && state_ff != ST_OUT) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == IDX_W'(TABLE_DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  mode_ff    <= req_mode;
                  pos_ff     <= req_sample_pos;
                  status_ff  <= req_status;
                  d1_ff      <= req_data_one;
                  d2_ff      <= req_data_two;
                  idx_ff     <= req_idx;
                  has_row_ff <= req_has_row;
                  state_ff   <= ST_LOOK;
               end
            end
            ST_LOOK: begin
               second_ff <= 1'b0;
               if (mode_ff == MODE_FLUSH && hit) begin
                  pair_ff  <= 1'b1;
                  opnd_ff  <= rd_ff.start;
                  state_ff <= ST_MUL_LO;
               end else if (event_ok && !is_note_on && is_note_stop && hit) begin
                  pair_ff  <= 1'b1;
                  opnd_ff  <= rd_ff.start;
                  state_ff <= ST_MUL_LO;
               end else if (event_ok && is_ctrl) begin
                  pair_ff  <= 1'b0;
                  opnd_ff  <= pos_ff;
                  state_ff <= ST_MUL_LO;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_MUL_LO: begin
               lo_ff    <= prod[47:16];
               state_ff <= ST_MUL_HI;
            end
            ST_MUL_HI: begin
               if (pair_ff && !second_ff) begin
                  // start tick done; convert the note end next
                  start_tick_ff <= tick;
                  second_ff     <= 1'b1;
                  opnd_ff       <= (mode_ff == MODE_FLUSH) ? eff_len : pos_ff;
                  state_ff      <= ST_MUL_LO;
               end else if (pair_ff) begin
                  end_tick_ff <= tick;
                  state_ff    <= ST_OUT;
               end else begin
                  start_tick_ff <= tick;
                  state_ff      <= ST_OUT;
               end
            end
            ST_OUT: begin
               // hold until the result register is free
               if (out_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_kind_ff    <= pair_ff ? KIND_NOTE : KIND_CTRL;
                  rsp_channel_ff <= CHAN_W'(status_ff[3:0]) + CHAN_W'(1);
                  rsp_number_ff  <= d1_ff;
                  rsp_value_ff   <= pair_ff ? rd_ff.velocity : d2_ff;
                  rsp_start_ff   <= start_tick_ff;
                  rsp_length_ff  <= pair_ff ? note_len : '0;
                  state_ff       <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_channel      = rsp_channel_ff;
   assign rsp_number       = rsp_number_ff;
   assign rsp_value        = rsp_value_ff;
   assign rsp_start_tick   = rsp_start_ff;
   assign rsp_length_ticks = rsp_length_ff;

`ifndef NO_ASSERTIONS
   // a completed note never has zero length
   a_note_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_NOTE) |-> (rsp_length_ff != '0))
      else $error("note result with zero length");

   // a controller result carries no length
   a_ctrl_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_CTRL) |-> (rsp_length_ff == '0))
      else $error("controller result with non-zero length");

   // the table is written only by the clearing pass or the decode step
   a_mem_wr: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_CLEAR || state_ff == ST_LOOK))
      else $error("table write outside clear or decode");

   // a new result comes only from the output step
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside output step");
`endif

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - MIDI note on/off pairing, one recorded track
// Walks a table of directed events, then three phases of random event streams
// with sender and receiver gaps. Every accepted event is run through a local
// pairing model with its own pending-note table; every result transfer is
// compared field by field with the oldest expected note or controller.
// ----------------------------------------------------------------------------
module testbench;
   import mnp_pkg::*;

   localparam int          ITEMS_PER_PHASE = 210;
   localparam int          RSP_HOLD_CYCLES = 400;
   localparam int          SETTLE_CYCLES   = 16;
   localparam int          DRAIN_LIMIT     = 20000;
   localparam int          RUN_LIMIT_NS    = 5_000_000;
   localparam logic [47:0] SAMPLE_MAX      = 48'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic              kind;
      logic [CHAN_W-1:0] channel;
      logic [MIDI_W-1:0] number;
      logic [MIDI_W-1:0] value;
      logic [TICK_W-1:0] start_tick;
      logic [TICK_W-1:0] length_ticks;
   } midi_result_type;

   typedef enum logic [1:0] {EXP_PREDICT, EXP_NONE, EXP_RESULT} row_check_type;
   typedef enum logic {ROW_EVENT, ROW_SETTINGS} row_op_type;

   typedef struct {
      row_op_type      op;
      logic            mode;
      logic [47:0]     pos;      // take length on a settings row
      logic [47:0]     ratio;
      logic [7:0]      status;
      logic [6:0]      data_one;
      logic [6:0]      data_two;
      row_check_type   check;
      midi_result_type result;
   } stim_row_type;

   localparam midi_result_type NO_RES = '0;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_mode = MODE_EVENT;
   logic [SAMPLE_W-1:0]   req_sample_pos = '0;
   logic [7:0]            req_status = '0;
   logic [MIDI_W-1:0]     req_data_one = '0;
   logic [MIDI_W-1:0]     req_data_two = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_kind;
   logic [CHAN_W-1:0]     rsp_channel;
   logic [MIDI_W-1:0]     rsp_number;
   logic [MIDI_W-1:0]     rsp_value;
   logic [TICK_W-1:0]     rsp_start_tick;
   logic [TICK_W-1:0]     rsp_length_ticks;

   // check selection travelling with the event on the request channel
   row_check_type         req_exp_sel = EXP_PREDICT;
   midi_result_type       req_exp_res = '0;

   // pairing model state
   bit                    note_live [TABLE_DEPTH];
   logic [SAMPLE_W-1:0]   note_start [TABLE_DEPTH];
   logic [MIDI_W-1:0]     note_vel [TABLE_DEPTH];
   logic [SAMPLE_W-1:0]   take_len = 48'd1;
   logic [RATIO_W-1:0]    tick_ratio = '0;
   midi_result_type       awaited_events[$];
   int                    fail_count = 0;

   // stimulus side
   stim_row_type          directed_rows[$];
   logic [10:0]           key_pool [8];
   logic [SAMPLE_W-1:0]   stim_span = 48'd1;
   int                    req_idle_pct = 0;
   int                    rsp_idle_pct = 0;
   int                    hold_requests = 0;
   int                    holds_done = 0;
   logic                  rsp_hold = 1'b0;

   midi_note_pairing_top DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_sample_pos   (req_sample_pos),
      .req_status       (req_status),
      .req_data_one     (req_data_one),
      .req_data_two     (req_data_two),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_channel      (rsp_channel),
      .rsp_number       (rsp_number),
      .rsp_value        (rsp_value),
      .rsp_start_tick   (rsp_start_tick),
      .rsp_length_ticks (rsp_length_ticks)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // floor(samples * ratio / 2^32) with ratio as unsigned Q0.32
   function automatic logic [TICK_W-1:0] samples_to_ticks(input logic [SAMPLE_W-1:0] samples);
      logic [79:0] product;
      product = {32'd0, samples} * {48'd0, tick_ratio};
      return product[79:32];
   endfunction

   // append a result to the tail of the awaited queue
   function automatic void queue_result(input midi_result_type res);
      awaited_events = {awaited_events, res};
   endfunction

   function automatic void pair_midi_event(
      input  logic mode, input logic [47:0] pos, input logic [7:0] status,
      input  logic [6:0] key, input logic [6:0] vel,
      output bit hit, output midi_result_type res);
      logic [3:0]          chan_lsb;
      logic [7:0]          msg_type;
      int unsigned         slot;
      bit                  has_row;
      logic [SAMPLE_W-1:0] span;
      logic [TICK_W-1:0]   on_tick;
      logic [TICK_W-1:0]   off_tick;
      hit      = 1'b0;
      res      = '0;
      chan_lsb = status[3:0];
      msg_type = status & STATUS_TYPE_MASK;
      has_row  = chan_lsb < NUM_CHANNELS;
      slot     = has_row ? chan_lsb * KEYS_PER_CHANNEL + key : 0;
      span     = (take_len == '0) ? 48'd1 : take_len;
      on_tick  = '0;
      off_tick = '0;
      if (mode == MODE_FLUSH) begin
         // flush: end a hanging note at the region end
         if (has_row && note_live[slot]) begin
            on_tick  = samples_to_ticks(note_start[slot]);
            off_tick = samples_to_ticks(span);
            hit      = 1'b1;
         end
      end else if (status >= STATUS_NOTE_OFF && status < STATUS_SYSTEM && pos < span) begin
         if (msg_type == STATUS_NOTE_ON && vel != '0) begin
            if (has_row) begin
               note_live[slot]  = 1'b1;
               note_start[slot] = pos;
               note_vel[slot]   = vel;
            end
         end else if (msg_type == STATUS_NOTE_ON || msg_type == STATUS_NOTE_OFF) begin
            if (has_row && note_live[slot]) begin
               on_tick  = samples_to_ticks(note_start[slot]);
               off_tick = samples_to_ticks(pos);
               hit      = 1'b1;
            end
         end else if (msg_type == STATUS_CTRL) begin
            res = '{KIND_CTRL, CHAN_W'(chan_lsb) + 5'd1, key, vel, samples_to_ticks(pos), '0};
            hit = 1'b1;
         end
      end
      if (hit && res.kind != KIND_CTRL) begin
         res = '{KIND_NOTE, CHAN_W'(chan_lsb) + 5'd1, key, note_vel[slot], on_tick,
                 (off_tick > on_tick) ? off_tick - on_tick : 48'd1};
         note_live[slot] = 1'b0;
      end
   endfunction

   function automatic int check_field(input string name, input logic [47:0] want,
                                      input logic [47:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin : scoreboard
      midi_result_type got;
      midi_result_type want;
      midi_result_type predicted;
      bit              hit;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_kind, rsp_channel, rsp_number, rsp_value, rsp_start_tick, rsp_length_ticks};
         if (awaited_events.size() == 0) begin
            $error("result transfer with nothing expected: 0x%0h", got);
            fail_count++;
         end else begin
            want = awaited_events.pop_front();
            fail_count += check_field("kind", want.kind, got.kind)
                        + check_field("channel", want.channel, got.channel)
                        + check_field("number", want.number, got.number)
                        + check_field("value", want.value, got.value)
                        + check_field("start_tick", want.start_tick, got.start_tick)
                        + check_field("length_ticks", want.length_ticks, got.length_ticks);
         end
      end
      if (!reset && csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TAKE_LENGTH:      take_len   = csr_wdata[SAMPLE_W-1:0];
            CSR_TICKS_PER_SAMPLE: tick_ratio = csr_wdata[RATIO_W-1:0];
            default: ;
         endcase
      end
      if (!reset && req_valid && req_ready) begin
         pair_midi_event(req_mode, req_sample_pos, req_status, req_data_one, req_data_two,
                         hit, predicted);
         case (req_exp_sel)
            EXP_RESULT:  queue_result(req_exp_res);
            EXP_PREDICT: if (hit) queue_result(predicted);
            default: ;
         endcase
      end
   end

   always @(posedge clock) begin
      rsp_ready <= !rsp_hold && ($urandom_range(99) >= rsp_idle_pct);
   end

   // long receiver hold-off, counted here so the sender keeps offering events
   initial begin
      forever begin
         @(posedge clock);
         if (hold_requests != holds_done) begin
            holds_done++;
            rsp_hold <= 1'b1;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            rsp_hold <= 1'b0;
         end
      end
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("midi_note_pairing_top verification failed");
      $finish;
   end

   function automatic logic [47:0] random_sample();
      return 48'({$urandom, $urandom});
   endfunction

   task automatic add_event_row(input logic mode, input logic [47:0] pos,
                                input logic [7:0] status, input logic [6:0] d1,
                                input logic [6:0] d2, input row_check_type check,
                                input midi_result_type result);
      stim_row_type row;
      row = '{ROW_EVENT, mode, pos, '0, status, d1, d2, check, result};
      directed_rows = {directed_rows, row};
   endtask

   task automatic add_settings_row(input logic [47:0] span, input logic [47:0] ratio);
      stim_row_type row;
      row = '{ROW_SETTINGS, MODE_EVENT, span, ratio, '0, '0, '0, EXP_NONE, NO_RES};
      directed_rows = {directed_rows, row};
   endtask

   task automatic send_event(input logic mode, input logic [47:0] pos, input logic [7:0] status,
                             input logic [6:0] d1, input logic [6:0] d2,
                             input row_check_type check, input midi_result_type result);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_sample_pos <= pos;
      req_status     <= status;
      req_data_one   <= d1;
      req_data_two   <= d2;
      req_exp_sel    <= check;
      req_exp_res    <= result;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // drop valid, then hold until every predicted result has been transferred
   task automatic drain_pending();
      int spins;
      req_valid <= 1'b0;
      spins = 0;
      @(posedge clock);
      while (awaited_events.size() != 0 && spins < DRAIN_LIMIT) begin
         @(posedge clock);
         spins++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [47:0] span, input logic [47:0] ratio);
      csr_valid <= 1'b1;
      csr_index <= CSR_TAKE_LENGTH;
      csr_wdata <= span;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= CSR_TICKS_PER_SAMPLE;
      csr_wdata <= ratio;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      stim_span = span;
   endtask

   task automatic send_random_event(output bit useful);
      logic [10:0] key;
      logic [47:0] span;
      logic [47:0] pos;
      logic [7:0]  status;
      logic [6:0]  num;
      logic [6:0]  vel;
      logic        mode;
      int unsigned pick;
      if ($urandom_range(15) == 0) key_pool[$urandom_range(7)] = 11'($urandom);
      key    = key_pool[$urandom_range(7)];
      span   = (stim_span == '0) ? 48'd1 : stim_span;
      pos    = random_sample() % span;
      num    = key[6:0];
      vel    = 7'($urandom);
      mode   = MODE_EVENT;
      useful = 1'b1;
      pick   = $urandom_range(99);
      if (pick < 30) begin
         status = STATUS_NOTE_ON | 8'(key[10:7]);
         vel    = 7'($urandom_range(1, 127));
      end else if (pick < 50) begin
         status = STATUS_NOTE_OFF | 8'(key[10:7]);
      end else if (pick < 58) begin
         status = STATUS_NOTE_ON | 8'(key[10:7]);
         vel    = '0;
      end else if (pick < 73) begin
         status = STATUS_CTRL | 8'($urandom_range(15));
         num    = 7'($urandom);
      end else if (pick < 83) begin
         // flush ignores the high nibble and the position; randomise both
         mode   = MODE_FLUSH;
         status = {4'($urandom), key[10:7]};
         pos    = random_sample();
      end else begin
         useful = 1'b0;
         status = 8'($urandom);
         num    = 7'($urandom);
         if (pick < 91) begin
            pos = random_sample();
         end else begin
            // late voice message
            status = status | STATUS_NOTE_OFF;
            pos    = span + random_sample() % (SAMPLE_MAX - span + 48'd1);
         end
      end
      send_event(mode, pos, status, num, vel, EXP_PREDICT, NO_RES);
   endtask

   initial begin : stimulus
      bit useful;
      bit paused;
      int useful_count;

      // after reset: take length 1, ratio 0, so every tick is zero
      add_event_row(MODE_EVENT, 48'd0, 8'hB0, 7'd7, 7'd100, EXP_RESULT,
                    '{KIND_CTRL, 5'd1, 7'd7, 7'd100, 48'd0, 48'd0});
      add_event_row(MODE_EVENT, 48'd1, 8'hB0, 7'd7, 7'd100, EXP_NONE, NO_RES);
      add_event_row(MODE_EVENT, 48'd0, 8'h90, 7'd60, 7'd127, EXP_NONE, NO_RES);
      add_event_row(MODE_EVENT, 48'd0, 8'h80, 7'd60, 7'd0, EXP_RESULT,
                    '{KIND_NOTE, 5'd1, 7'd60, 7'd127, 48'd0, 48'd1});
      add_event_row(MODE_EVENT, 48'd0, 8'h80, 7'd60, 7'd0, EXP_NONE, NO_RES);
      add_event_row(MODE_EVENT, 48'd0, 8'hF0, 7'd1, 7'd2, EXP_NONE, NO_RES);
      add_event_row(MODE_EVENT, 48'd0, 8'h7F, 7'd127, 7'd127, EXP_NONE, NO_RES);
      add_event_row(MODE_EVENT, 48'd0, 8'hA0, 7'd60, 7'd64, EXP_NONE, NO_RES);
      add_event_row(MODE_EVENT, 48'd0, 8'hFF, 7'd0, 7'd0, EXP_NONE, NO_RES);
      // widest take and ratio
      add_settings_row(SAMPLE_MAX, SAMPLE_MAX);
      add_event_row(MODE_EVENT, 48'hFFFF_FFFF_FFFE, 8'h9F, 7'd127, 7'd1, EXP_NONE, NO_RES);
      add_event_row(MODE_FLUSH, 48'h1234_5678_9ABC, 8'h0F, 7'd127, 7'd0, EXP_PREDICT, NO_RES);
      add_event_row(MODE_FLUSH, 48'd0, 8'h0F, 7'd127, 7'd0, EXP_NONE, NO_RES);
      // stop arriving before its start gives length 1
      add_event_row(MODE_EVENT, 48'd1000, 8'h93, 7'd0, 7'd50, EXP_NONE, NO_RES);
      add_event_row(MODE_EVENT, 48'd500, 8'h93, 7'd0, 7'd0, EXP_PREDICT, NO_RES);
      // retrigger overwrites start and velocity
      add_event_row(MODE_EVENT, 48'd10, 8'h95, 7'd64, 7'd20, EXP_NONE, NO_RES);
      add_event_row(MODE_EVENT, 48'd30, 8'h95, 7'd64, 7'd90, EXP_NONE, NO_RES);
      add_event_row(MODE_EVENT, 48'd40000, 8'h85, 7'd64, 7'd0, EXP_PREDICT, NO_RES);
      add_event_row(MODE_EVENT, 48'hFFFF_FFFF_FFFE, 8'hBF, 7'd127, 7'd127, EXP_PREDICT, NO_RES);
      add_event_row(MODE_EVENT, SAMPLE_MAX, 8'hBF, 7'd127, 7'd127, EXP_NONE, NO_RES);
      add_event_row(MODE_EVENT, 48'd7, 8'h92, 7'd5, 7'd33, EXP_NONE, NO_RES);
      add_event_row(MODE_FLUSH, SAMPLE_MAX, 8'hF2, 7'd5, 7'd127, EXP_PREDICT, NO_RES);
      // zero take length behaves as one sample
      add_settings_row(48'd0, SAMPLE_MAX);
      add_event_row(MODE_EVENT, 48'd0, 8'hB4, 7'd0, 7'd0, EXP_RESULT,
                    '{KIND_CTRL, 5'd5, 7'd0, 7'd0, 48'd0, 48'd0});
      add_event_row(MODE_EVENT, 48'd1, 8'hB4, 7'd0, 7'd0, EXP_NONE, NO_RES);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].op == ROW_SETTINGS) begin
            drain_pending();
            apply_settings(directed_rows[i].pos, directed_rows[i].ratio);
         end else begin
            send_event(directed_rows[i].mode, directed_rows[i].pos, directed_rows[i].status,
                       directed_rows[i].data_one, directed_rows[i].data_two,
                       directed_rows[i].check, directed_rows[i].result);
         end
      end
      drain_pending();

      foreach (key_pool[i]) key_pool[i] = 11'($urandom);
      paused = 1'b0;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               req_idle_pct = 17;
               rsp_idle_pct <= 53;
               apply_settings(random_sample(), 48'($urandom));
            end
            1: begin
               req_idle_pct = 53;
               rsp_idle_pct <= 17;
               apply_settings(48'($urandom_range(200, 60000)), random_sample());
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct <= 0;
               apply_settings(SAMPLE_MAX, 48'($urandom_range(1, 32'h0100_0000)));
               hold_requests <= hold_requests + 1;
            end
         endcase
         useful_count = 0;
         while (useful_count < ITEMS_PER_PHASE) begin
            if (phase == 2 && !paused && useful_count == ITEMS_PER_PHASE / 2) begin
               // pause the sender until everything is out, then retune
               paused = 1'b1;
               drain_pending();
               apply_settings(48'($urandom_range(1000, 5000)), {16'($urandom), 32'hFFFF_FFFF});
            end
            send_random_event(useful);
            useful_count += useful;
         end
         drain_pending();
      end

      if (awaited_events.size() != 0)
         $error("%0d expected results never arrived", awaited_events.size());
      if (fail_count == 0 && awaited_events.size() == 0) begin
         $display("midi_note_pairing_top verification clean");
      end else begin
         $display("midi_note_pairing_top verification failed");
      end
      $finish;
   end

endmodule
